// File: src/assert_macros.svh
// assertion macros for the image checker core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: src/imcc_pkg.sv
// types, constants and crc helpers for the image checker core
package imcc_pkg;

	localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
	localparam logic [31:0] MAGIC0_RESET  = 32'h4649_4C41;
	localparam logic [31:0] MAGIC1_RESET  = 32'h4D52_5350;
	localparam logic [31:0] WORD_BYTES    = 32'd4;
	localparam logic [31:0] MAGIC_BYTES   = 32'd8;

	localparam logic [1:0] CFG_MAGIC0 = 2'd0;
	localparam logic [1:0] CFG_MAGIC1 = 2'd1;

	localparam logic [1:0] ST_PASS    = 2'd0;
	localparam logic [1:0] ST_FAIL    = 2'd1;
	localparam logic [1:0] ST_LEN_BAD = 2'd2;

	typedef struct packed {
		logic adv;
		logic clr;
	} imcc_ctl_t;

	typedef struct packed {
		logic        magic_match;
		logic        pattern_match;
		logic        short_img;
		logic [31:0] bad_offset;
	} imcc_chk_t;

	typedef struct packed {
		logic [31:0] first_bad_offset;
		logic [31:0] stored_crc;
		logic [31:0] computed_crc;
		logic        crc_good;
		logic        pattern_good;
		logic        magic_good;
		logic [1:0]  status;
	} imcc_result_t;

	typedef logic [31:0][31:0] crc_cols_t;

	function automatic crc_cols_t crc_cols_build();
		crc_cols_t   cols;
		logic [31:0] c;
		for (int i = 0; i < 32; i++) begin
			c = 32'd1 << i;
			for (int k = 0; k < 32; k++) begin
				c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
			end
			cols[i] = c;
		end
		return cols;
	endfunction

	localparam crc_cols_t CRC_COLS = crc_cols_build();

	// one word of reflected crc as an xor of precomputed columns
	function automatic logic [31:0] crc_update(input logic [31:0] x);
		logic [31:0] nxt;
		nxt = '0;
		for (int i = 0; i < 32; i++) begin
			if (x[i]) begin
				nxt = nxt ^ CRC_COLS[i];
			end
		end
		return nxt;
	endfunction

endpackage

// File: src/image_magic_pattern_crc_checker_core.sv
// top level of the image magic, offset pattern and crc checker
//
//  channel   dir  data                                   side
//  s_axis    in   tdata[31:0] data word                  tlast marks trailer
//  m_axis    out  tdata[103:0] result, see port comment  one word per trailer
//  cfg       in   cfg_wdata, cfg_index 0 magic0, 1 magic1
//
// one word per cycle unless a trailer stalls, through a single input register stage
// res_q loads as the trailer leaves the input stage, later while m_axis is held
// arst_n clears the magic registers to their defaults and all check state
// a trailer waits while the result register is held full and the input stalls behind it
`include "assert_macros.svh"

module image_magic_pattern_crc_checker_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [31:0]  s_axis_tdata,   // data_word
	input  logic         s_axis_tlast,   // last_word
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status[1:0] magic_good[2] pattern_good[3] crc_good[4] computed_crc[36:5]
	// stored_crc[68:37] first_bad_offset[100:69] zero[103:101]
	output logic [103:0] m_axis_tdata
);
	import imcc_pkg::*;

	logic [31:0]  magic0_q;
	logic [31:0]  magic1_q;
	logic         valid_s1;
	logic [31:0]  word_s1;
	logic         last_s1;
	logic         consume;
	logic         out_valid_q;
	imcc_result_t res_q;
	imcc_result_t res_d;
	imcc_ctl_t    ctl;
	imcc_chk_t    chk;
	logic [31:0]  crc;
	logic [31:0]  computed;
	logic         crc_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic0_q <= MAGIC0_RESET;
			magic1_q <= MAGIC1_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAGIC0: magic0_q <= cfg_wdata;
				CFG_MAGIC1: magic1_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign consume       = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			word_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	assign ctl.adv = consume && !last_s1;
	assign ctl.clr = consume && last_s1;

	imcc_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.word   (word_s1),
		.crc    (crc)
	);

	imcc_pattern u_pattern (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.word   (word_s1),
		.magic0 (magic0_q),
		.magic1 (magic1_q),
		.chk    (chk)
	);

	assign computed = ~crc;
	assign crc_ok   = (computed == word_s1);

	always_comb begin
		res_d            = '0;
		res_d.stored_crc = word_s1;
		if (chk.short_img) begin
			res_d.status = ST_LEN_BAD;
		end else begin
			res_d.magic_good       = chk.magic_match;
			res_d.pattern_good     = chk.pattern_match;
			res_d.crc_good         = crc_ok;
			res_d.computed_crc     = computed;
			res_d.first_bad_offset = chk.bad_offset;
			res_d.status = (chk.magic_match && chk.pattern_match && crc_ok) ?
				ST_PASS : ST_FAIL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.clr) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			res_q <= res_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, res_q};

	`ASSERT_IMPL(a_pass_all_good, out_valid_q && res_q.status == ST_PASS,
		res_q.magic_good && res_q.pattern_good && res_q.crc_good)
	`ASSERT_IMPL(a_short_clean, out_valid_q && res_q.status == ST_LEN_BAD,
		!res_q.magic_good && !res_q.crc_good && res_q.computed_crc == 32'd0)
	`ASSERT_NEXT(a_trailer_result, ctl.clr, out_valid_q)
	`ASSERT_IMPL(a_status_code, out_valid_q,
		res_q.status == ST_PASS || res_q.status == ST_FAIL || res_q.status == ST_LEN_BAD)

endmodule

// File: src/imcc_crc.sv
// running crc-32 register with one-word parallel update
module imcc_crc (
	input  logic                clk,
	input  logic                arst_n,
	input  imcc_pkg::imcc_ctl_t ctl,
	input  logic [31:0]         word,
	output logic [31:0]         crc
);
	import imcc_pkg::*;

	logic [31:0] crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (ctl.clr) begin
			crc_q <= CRC_INIT;
		end else if (ctl.adv) begin
			crc_q <= crc_update(crc_q ^ word);
		end
	end

	assign crc = crc_q;

endmodule

// File: src/imcc_pattern.sv
// byte offset counter, magic and offset-pattern checks
module imcc_pattern (
	input  logic                clk,
	input  logic                arst_n,
	input  imcc_pkg::imcc_ctl_t ctl,
	input  logic [31:0]         word,
	input  logic [31:0]         magic0,
	input  logic [31:0]         magic1,
	output imcc_pkg::imcc_chk_t chk
);
	import imcc_pkg::*;

	logic [31:0] offset_q;
	logic        magic_q;
	logic        pattern_q;
	logic [31:0] bad_q;
	logic        is_w0;
	logic        is_w1;
	logic        magic_miss;
	logic        body_miss;

	assign is_w0      = (offset_q == 32'd0);
	assign is_w1      = (offset_q == WORD_BYTES);
	assign magic_miss = (is_w0 && (word != magic0)) || (is_w1 && (word != magic1));
	assign body_miss  = !is_w0 && !is_w1 && (word != offset_q) && pattern_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q  <= '0;
			magic_q   <= 1'b1;
			pattern_q <= 1'b1;
			bad_q     <= '0;
		end else if (ctl.clr) begin
			offset_q  <= '0;
			magic_q   <= 1'b1;
			pattern_q <= 1'b1;
			bad_q     <= '0;
		end else if (ctl.adv) begin
			offset_q <= offset_q + WORD_BYTES;
			if (magic_miss) begin
				magic_q <= 1'b0;
			end
			if (body_miss) begin
				pattern_q <= 1'b0;
				bad_q     <= offset_q;
			end
		end
	end

	assign chk.magic_match   = magic_q;
	assign chk.pattern_match = pattern_q;
	assign chk.short_img     = (offset_q < MAGIC_BYTES);
	assign chk.bad_offset    = bad_q;

endmodule
